### rtl/afrm_pkg.sv
// shared types and constants of the frame rms meter
package afrm_pkg;

    localparam int MAX_FRAME_SAMPLES = 65536;

    localparam int MAG_W  = 32;
    localparam int SQ_W   = 33;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int ROOT_W = SUM_W / 2;
    localparam int LVL_W  = 16;
    // shared subtractor covers the divide remainder and the root remainder
    localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 3) ? CNT_W + 1 : ROOT_W + 3;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_SAMPLES);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        FMT_FLOAT = 2'd0,
        FMT_INT16 = 2'd1,
        FMT_INT32 = 2'd2,
        FMT_NONE  = 2'd3
    } fmt_t;

endpackage

### rtl/afrm_norm.sv
// sample normalization to a q1.31 magnitude and its registered square
module afrm_norm (
    input  logic                     clk,
    input  logic                     load,
    input  afrm_pkg::fmt_t           format,
    input  logic [31:0]              raw,
    output logic [afrm_pkg::SQ_W-1:0] sq,
    output logic                     clip
);
    import afrm_pkg::*;

    localparam logic [MAG_W-1:0] FULL_SCALE     = 32'h8000_0000;
    localparam logic [MAG_W-1:0] FULL_SCALE_M1  = 32'h7FFF_FFFF;

    logic             neg;
    logic [7:0]       expo;
    logic [22:0]      mant;
    logic [MAG_W-1:0] sig_ext;
    logic [7:0]       up_amt;
    logic [7:0]       dn_amt;
    logic [15:0]      abs16;
    logic [MAG_W-1:0] abs32;
    logic [MAG_W-1:0] mag_next;
    logic             clip_next;

    logic [MAG_W-1:0]   mag_reg;
    logic               clip_reg;
    logic [2*MAG_W-1:0] prod;
    logic [SQ_W-1:0]    sq_reg;

    always_comb
    begin
        neg     = raw[31];
        expo    = raw[30:23];
        mant    = raw[22:0];
        sig_ext = {8'b0, 1'b1, mant};
        up_amt  = expo - 8'd119;
        dn_amt  = 8'd119 - expo;
        abs16   = raw[15] ? (~raw[15:0] + 16'd1) : raw[15:0];
        abs32   = raw[31] ? (~raw + 32'd1) : raw;

        mag_next  = '0;
        clip_next = 1'b0;
        case (format)
            FMT_FLOAT:
            begin
                if (expo == 8'hFF)
                begin
                    clip_next = 1'b1;
                    if (mant != 23'd0)
                        mag_next = '0;
                    else
                        mag_next = neg ? FULL_SCALE : FULL_SCALE_M1;
                end
                else if (expo >= 8'd127)
                begin
                    // exactly -1.0 is representable
                    if (neg && expo == 8'd127 && mant == 23'd0)
                        mag_next = FULL_SCALE;
                    else
                    begin
                        clip_next = 1'b1;
                        mag_next  = neg ? FULL_SCALE : FULL_SCALE_M1;
                    end
                end
                else if (expo == 8'd0)
                    mag_next = '0;
                else if (expo >= 8'd119)
                    mag_next = sig_ext << up_amt[2:0];
                else if (dn_amt >= 8'd25)
                    mag_next = '0;
                else
                    mag_next = sig_ext >> dn_amt[4:0];
            end
            FMT_INT16: mag_next = {abs16, 16'b0};
            FMT_INT32: mag_next = abs32;
            FMT_NONE:  mag_next = '0;
            default:   mag_next = '0;
        endcase
    end

    assign prod = mag_reg * mag_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg  <= mag_next;
            clip_reg <= clip_next;
        end
        // square reduced to q1.32, max is 2^32
        sq_reg <= prod[SQ_W+29:30];
    end

    assign sq   = sq_reg;
    assign clip = clip_reg;

endmodule

### rtl/afrm_divsqrt.sv
// shared subtract unit stepping a restoring divide and then an integer root
module afrm_divsqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [afrm_pkg::SUM_W-1:0]  dividend,
    input  logic [afrm_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [afrm_pkg::ROOT_W-1:0] root
);
    import afrm_pkg::*;

    localparam int REM_W = SUB_W - 2;

    typedef enum logic [2:0] {
        DS_IDLE = 3'b001,
        DS_DIV  = 3'b010,
        DS_SQRT = 3'b100
    } ds_state_t;

    ds_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;

    logic [SUM_W-1:0]   work_reg, work_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0]   divisor_reg;

    logic [SUB_W-1:0]   sub_a;
    logic [SUB_W-1:0]   sub_b;
    logic [SUB_W:0]     diff;
    logic               ge;
    logic [SUB_W-1:0]   sel;

    // the one shared subtract and compare
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            DS_DIV:
            begin
                sub_a = SUB_W'({rem_reg[CNT_W-1:0], work_reg[SUM_W-1]});
                sub_b = SUB_W'(divisor_reg);
            end
            DS_SQRT:
            begin
                sub_a = {rem_reg, work_reg[SUM_W-1:SUM_W-2]};
                sub_b = SUB_W'({root_reg, 2'b01});
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = ~diff[SUB_W];
        sel  = ge ? diff[SUB_W-1:0] : sub_a;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        work_next  = work_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    state_next = DS_DIV;
                    step_next  = '0;
                    work_next  = dividend;
                    rem_next   = '0;
                end
            end
            DS_DIV:
            begin
                // quotient bits shift in where dividend bits shift out
                work_next = {work_reg[SUM_W-2:0], ge};
                rem_next  = sel[REM_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = DS_SQRT;
                    step_next  = '0;
                    rem_next   = '0;
                    root_next  = '0;
                end
            end
            DS_SQRT:
            begin
                work_next = {work_reg[SUM_W-3:0], 2'b00};
                rem_next  = sel[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = DS_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (start && state_reg == DS_IDLE)
            divisor_reg <= divisor;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/audio_frame_rms_meter.sv
// frame rms level meter top level: sequencer, accumulator and result register
//
// sample items enter on in_valid/in_stall with sample_value and last_of_frame.
// sample_format (cfg_write/cfg_data) picks float32, int16, int32 or unsupported;
// write it only while no frame result is being worked on.
// each sample passes decode, square on the 32x32 multiplier, then the
// saturating add into the 48-bit sum; no new sample is taken before that add.
// on the item marked last_of_frame the frame is closed in a final state, then
// the shared subtract unit runs 48 steps of restoring divide (sum / count)
// and 24 steps of integer root before the result is loaded. the unsupported
// format skips the divide and root.
// the result (rms_level, clipped) sits in an output register under out_valid;
// sample items of the next frame are taken while it waits, and only the next
// frame's close waits for out_stall to drop.
// reset clears the sum, count, clip flag and format (float32) and empties
// the output register.
module audio_frame_rms_meter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_value,
    input  logic        last_of_frame,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] rms_level,
    output logic        clipped
);
    import afrm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ   = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_FIN  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    fmt_t              format_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              clip_reg, clip_next;
    logic              last_reg;
    logic              skip_reg;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              res_clip_reg, res_clip_next;

    logic              out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]  rms_level_reg;
    logic              clipped_reg;

    logic              accept;
    logic              out_load;
    logic [SQ_W-1:0]   sq;
    logic              sq_clip;
    logic [SUM_W:0]    sum_ext;
    logic              root_start;
    logic              root_done;
    logic [ROOT_W-1:0] root;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    afrm_norm u_norm (
        .clk    (clk),
        .load   (accept),
        .format (format_reg),
        .raw    (sample_value),
        .sq     (sq),
        .clip   (sq_clip)
    );

    assign root_start = (state_reg == ST_FIN) && (format_reg != FMT_NONE)
                        && (count_reg != '0);

    afrm_divsqrt u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (root_done),
        .root     (root)
    );

    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(sq);

    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        clip_next     = clip_reg;
        level_next    = level_reg;
        res_clip_next = res_clip_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (skip_reg)
                    clip_next = 1'b1;
                else
                begin
                    sum_next   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    clip_next  = clip_reg | sq_clip;
                end
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                // divider, when started, takes the sum and count as this state ends; start a new frame
                res_clip_next = clip_reg;
                sum_next      = '0;
                count_next    = '0;
                clip_next     = 1'b0;
                if (root_start)
                    state_next = ST_ROOT;
                else
                begin
                    level_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    level_next = (|root[ROOT_W-1:LVL_W]) ? {LVL_W{1'b1}}
                                                         : root[LVL_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            format_reg    <= FMT_FLOAT;
            sum_reg       <= '0;
            count_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
                format_reg <= fmt_t'(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_of_frame;
            // frame already full: sample is dropped and flagged
            skip_reg <= (count_reg == MAX_CNT);
        end
        level_reg    <= level_next;
        res_clip_reg <= res_clip_next;
        if (out_load)
        begin
            rms_level_reg <= level_reg;
            clipped_reg   <= res_clip_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign rms_level = rms_level_reg;
    assign clipped   = clipped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("sample count beyond frame bound");

    a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == ST_ROOT)
        else $error("root unit finished outside of root wait");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result shown without a closed frame");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> sum_reg == '0 && count_reg == '0 && !clip_reg)
        else $error("frame state not cleared after close");

endmodule

### test/tb_top.sv
// testbench for the frame rms level meter: predicts each frame level and checks every result
module tb_top;
    import afrm_pkg::*;

    localparam int        CYCLE_LIMIT   = 3000000;
    localparam int        SETTLE_CYCLES = 120;
    localparam bit [63:0] FULL_MAG      = 64'd1 << 31;

    typedef struct packed {
        logic [15:0] level;
        logic        clip;
    } frame_level_t;

    class rms_frame_tracker;
        fmt_t         fmt;
        bit [63:0]    acc_sum;
        int unsigned  acc_count;
        bit           frame_clip;
        frame_level_t pending_levels[$];
        int unsigned  mismatches;

        function new();
            fmt        = FMT_FLOAT;
            acc_sum    = '0;
            acc_count  = 0;
            frame_clip = 1'b0;
            mismatches = 0;
        endfunction

        // q1.31 magnitude of an ieee single, flags clips and nan
        function bit [63:0] float_mag(bit [31:0] b);
            bit [7:0]  ex;
            bit [63:0] sig;
            ex  = b[30:23];
            sig = {40'd0, 1'b1, b[22:0]};
            if (ex == 8'hFF)
            begin
                frame_clip = 1'b1;
                if (b[22:0] != 23'd0)
                    return 64'd0;
                return b[31] ? FULL_MAG : FULL_MAG - 64'd1;
            end
            if (ex >= 8'd127)
            begin
                if (b[31] && ex == 8'd127 && b[22:0] == 23'd0)
                    return FULL_MAG;
                frame_clip = 1'b1;
                return b[31] ? FULL_MAG : FULL_MAG - 64'd1;
            end
            if (ex == 8'd0)
                return 64'd0;
            if (ex >= 8'd119)
                return sig << (ex - 8'd119);
            if (8'd119 - ex >= 8'd25)
                return 64'd0;
            return sig >> (8'd119 - ex);
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] x);
            bit [63:0] root;
            bit [63:0] trial;
            root = '0;
            for (int i = 31; i >= 0; i--)
            begin
                trial = root | (64'd1 << i);
                if (trial * trial <= x)
                    root = trial;
            end
            return root;
        endfunction

        function void take_sample(bit [31:0] v, bit last);
            bit [63:0]    mag;
            bit [63:0]    sq;
            bit [63:0]    root;
            bit [15:0]    half;
            bit [15:0]    half_neg;
            bit [31:0]    word_neg;
            frame_level_t res;
            if (acc_count >= MAX_FRAME_SAMPLES)
                frame_clip = 1'b1;
            else
            begin
                half     = v[15:0];
                half_neg = -half;
                word_neg = -v;
                mag      = '0;
                case (fmt)
                    FMT_FLOAT: mag = float_mag(v);
                    FMT_INT16:
                    begin
                        mag = half[15] ? half_neg : half;
                        mag = mag << 16;
                    end
                    FMT_INT32: mag = v[31] ? word_neg : v;
                    default:   mag = '0;
                endcase
                sq = (mag * mag) >> 30;
                acc_sum = (64'(SUM_MAX) - acc_sum < sq) ? 64'(SUM_MAX) : acc_sum + sq;
                acc_count++;
            end
            if (!last)
                return;
            res.level = '0;
            if (fmt != FMT_NONE && acc_count != 0)
            begin
                root = int_sqrt(acc_sum / acc_count);
                res.level = (root > 64'd65535) ? 16'hFFFF : root[15:0];
            end
            res.clip = frame_clip;
            pending_levels.push_back(res);
            acc_sum    = '0;
            acc_count  = 0;
            frame_clip = 1'b0;
        endfunction

        function void check_level(logic [15:0] level, logic clip);
            frame_level_t want;
            if (pending_levels.size() == 0)
            begin
                $error("rms result with no frame closed: rms_level %0d clipped %0b",
                       level, clip);
                mismatches++;
                return;
            end
            want = pending_levels.pop_front();
            if (level !== want.level)
            begin
                $error("rms_level: expected %0d, got %0d", want.level, level);
                mismatches++;
            end
            if (clip !== want.clip)
            begin
                $error("clipped: expected %0b, got %0b", want.clip, clip);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_write     = 1'b0;
    logic [1:0]  cfg_data      = FMT_FLOAT;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [31:0] sample_value  = '0;
    logic        last_of_frame = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [15:0] rms_level;
    logic        clipped;

    int unsigned      cycles         = 0;
    int               send_gap_pct   = 17;
    int               recv_stall_pct = 62;
    rms_frame_tracker tracker;

    audio_frame_rms_meter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_value  (sample_value),
        .last_of_frame (last_of_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rms_level     (rms_level),
        .clipped       (clipped)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall, check every accepted item
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
            tracker.check_level(rms_level, clipped);
    end

    task automatic send_sample(input logic [31:0] v, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample_value  <= v;
        last_of_frame <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_sample(v, last);
    endtask

    // wait for every frame result, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input fmt_t f);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= f;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.fmt = f;
    endtask

    function automatic logic [31:0] random_sample(input fmt_t f);
        logic [31:0] r;
        int          pick;
        r    = $urandom;
        pick = $urandom_range(31);
        case (f)
            FMT_FLOAT:
            begin
                case (pick)
                    0: r[30:23] = 8'hFF;
                    1:
                    begin
                        r[30:23] = 8'hFF;
                        r[22:0]  = '0;
                    end
                    2: r[30:23] = 8'($urandom_range(254, 127));
                    3: r = 32'hBF80_0000;
                    4: r[30:23] = 8'h00;
                    5: r[30:23] = 8'($urandom_range(118, 1));
                    6: ;
                    default: r[30:23] = 8'($urandom_range(126, 110));
                endcase
            end
            FMT_INT16:
            begin
                case (pick)
                    0: r[15:0] = 16'h8000;
                    1: r[15:0] = 16'h7FFF;
                    2: r[15:0] = 16'hFFFF;
                    3: r[15:0] = 16'h0000;
                    default: ;
                endcase
            end
            FMT_INT32:
            begin
                case (pick)
                    0: r = 32'h8000_0000;
                    1: r = 32'h7FFF_FFFF;
                    2: r = 32'hFFFF_FFFF;
                    3: r = 32'h0000_0000;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic run_frames(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            for (int k = 0; k < len; k++)
                send_sample(random_sample(tracker.fmt), k == len - 1);
            sent += len;
        end
        // sometimes leave a frame open so it spans the next format
        if ($urandom_range(1) == 1)
        begin
            len = $urandom_range(3, 1);
            for (int k = 0; k < len; k++)
                send_sample(random_sample(tracker.fmt), 1'b0);
        end
    endtask

    initial
    begin
        fmt_t order [4];
        order   = '{FMT_INT16, FMT_FLOAT, FMT_INT32, FMT_NONE};
        tracker = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_format(FMT_FLOAT);
        send_sample(32'h3F00_0000, 1'b1);
        // exactly -1.0 is full scale without a clip
        send_sample(32'hBF80_0000, 1'b1);
        send_sample(32'h3F80_0000, 1'b0);
        send_sample(32'h7F80_0000, 1'b0);
        send_sample(32'hFF80_0000, 1'b0);
        send_sample(32'h7FC0_0001, 1'b1);
        // subnormals, zero and tiny values
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h807F_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h2F00_0000, 1'b0);
        send_sample(32'h3380_0000, 1'b1);

        write_format(FMT_INT16);
        send_sample(32'hFFFF_8000, 1'b0);
        send_sample(32'h0000_7FFF, 1'b0);
        send_sample(32'h1234_0000, 1'b1);

        write_format(FMT_INT32);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        // frame closed under the unsupported format reads zero
        write_format(FMT_NONE);
        send_sample(32'hDEAD_BEEF, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap_pct   = (phase == 0) ? 17 : (phase == 1) ? 62 : 0;
            recv_stall_pct = (phase == 0) ? 62 : (phase == 1) ? 17 : 0;
            for (int i = 0; i < 4; i++)
            begin
                write_format(order[(i + phase) % 4]);
                run_frames(135);
            end
        end
        send_sample(random_sample(tracker.fmt), 1'b1);

        settle();
        if (tracker.mismatches == 0 && tracker.pending_levels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
